// ===== hw/rtl/gmd_pkg.sv =====
// shared types, codes and constants of the gate motor drive controller
package gmd_pkg;

    localparam int QUOT_W = 17;
    localparam int PROD_W = 49;
    localparam int TRAVEL_W = 20;
    localparam int CNT_W = $clog2(QUOT_W + 1);

    localparam logic [16:0]        POS_FULL        = 17'h10000;
    localparam logic signed [15:0] SPEED_FULL      = 16'sd16384;
    localparam logic [16:0]        SPEED_DELTA_MIN = 17'd16;
    localparam logic [14:0]        SPEED_HIGH      = 15'd15565;

    localparam logic [19:0] RST_OPEN_TRAVEL  = 20'd20000;
    localparam logic [19:0] RST_CLOSE_TRAVEL = 20'd20000;
    localparam logic [14:0] RST_CUR_LIMIT    = 15'd5000;
    localparam logic [15:0] RST_OC_HOLD      = 16'd500;

    typedef enum logic [2:0] {
        ACT_TICK     = 3'd0,
        ACT_OPEN_SW  = 3'd1,
        ACT_CLOSE_SW = 3'd2,
        ACT_BARRIER  = 3'd3,
        ACT_OC_CHECK = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_OPENING = 2'd1,
        MODE_CLOSING = 2'd2
    } t_motion_mode;

    typedef enum logic [1:0] {
        JOB_NONE   = 2'd0,
        JOB_DELETE = 2'd1,
        JOB_REOPEN = 2'd2
    } t_job_req;

    typedef enum logic [1:0] {
        CFG_OPEN_TRAVEL  = 2'd0,
        CFG_CLOSE_TRAVEL = 2'd1,
        CFG_CUR_LIMIT    = 2'd2,
        CFG_OC_HOLD      = 2'd3
    } t_cfg_index;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_MUL,
        SEQ_LOAD,
        SEQ_DIV,
        SEQ_DONE
    } t_seq_state;

    typedef struct packed {
        logic [2:0]         action;
        logic [31:0]        now_ms;
        logic signed [15:0] speed_cmd;
        logic               speed_valid;
        logic               open_switch_n;
        logic               close_switch_n;
        logic               barrier_n;
        logic signed [15:0] current_ma;
    } t_in_word;

    typedef struct packed {
        logic [7:0]  pwm_duty;
        logic        direction;
        logic [16:0] position;
        logic [1:0]  motion_state;
        logic [1:0]  job_request;
        logic        overcurrent;
    } t_out_word;

    typedef struct packed {
        logic [1:0]  index;
        logic [19:0] data;
    } t_cfg_word;

    typedef struct packed {
        logic              done;
        logic              sat;
        logic [QUOT_W-1:0] quot;
    } t_div_res;

    typedef struct packed {
        t_motion_mode       mode;
        logic signed [15:0] speed;
        logic [16:0]        pos;
        logic [16:0]        seg_pos;
        logic [31:0]        seg_time;
    } t_motion;

endpackage

// ===== hw/rtl/gmd_stream_if.sv =====
// valid/ready channel carrying one word of a chosen payload type
interface gmd_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/gmd_div.sv =====
// restoring divider for the position step, saturates when the quotient overflows
module gmd_div (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [48:0]           i_dividend,
    input  logic [19:0]           i_divisor,
    output gmd_pkg::t_div_res     o_res
);
    import gmd_pkg::*;

    logic                r_busy;
    logic                r_done;
    logic                r_sat;
    logic [CNT_W-1:0]    r_cnt;
    logic [TRAVEL_W-1:0] r_rem;
    logic [QUOT_W-1:0]   r_low;
    logic [QUOT_W-1:0]   r_quot;
    logic [TRAVEL_W-1:0] r_div;

    logic [TRAVEL_W:0]   w_trial;
    logic                w_fit;
    logic                w_ovf;

    assign w_trial = {r_rem, r_low[QUOT_W-1]};
    assign w_fit   = w_trial >= {1'b0, r_div};
    // quotient needs more than QUOT_W bits when the high part reaches the divisor
    assign w_ovf   = i_dividend[PROD_W-1:QUOT_W] >= {12'd0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_sat <= w_ovf;
                r_div <= i_divisor;
                r_rem <= i_dividend[QUOT_W+TRAVEL_W-1:QUOT_W];
                r_low <= i_dividend[QUOT_W-1:0];
                r_quot <= '0;
                r_cnt <= CNT_W'(QUOT_W);
                if (w_ovf) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_rem  <= w_fit ? TRAVEL_W'(w_trial - {1'b0, r_div}) : w_trial[TRAVEL_W-1:0];
                r_quot <= {r_quot[QUOT_W-2:0], w_fit};
                r_low  <= {r_low[QUOT_W-2:0], 1'b0};
                r_cnt  <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_res.done = r_done;
    assign o_res.sat  = r_sat;
    assign o_res.quot = r_quot;

endmodule

// ===== hw/rtl/gate_motor_drive_controller.sv =====
// top level of the sliding gate motor drive controller
//
//  channel   dir  word type    contents
//  i_cfg     in   t_cfg_word   register index, write data (always ready)
//  i_in      in   t_in_word    action, timestamp, speed command, switches, current
//  o_out     out  t_out_word   pwm, direction, position, state, job request, flag
//
// a moving control tick reaches the output register through multiply, divider load,
// 17 divider steps, finish and commit; an overflowing quotient skips the divider steps;
// any other word goes from accept straight to finish and commit
// one word at a time: i_in is ready only while the sequencer is idle
// a finished word waits in the done state while o_out holds the previous one
// synchronous active-low reset clears the controller state and loads the config defaults
module gate_motor_drive_controller (
    input  logic          i_clk,
    input  logic          i_rst_n,
    gmd_stream_if.sink    i_cfg,
    gmd_stream_if.sink    i_in,
    gmd_stream_if.source  o_out
);
    import gmd_pkg::*;

    // configuration registers
    logic [19:0] r_open_travel;
    logic [19:0] r_close_travel;
    logic [14:0] r_cur_limit;
    logic [15:0] r_oc_hold;

    // controller state
    t_motion     r_m,   n_m;
    logic        r_ocf, n_ocf;
    logic [31:0] r_ocs, n_ocs;

    // sequencer and working registers
    t_seq_state         r_seq, n_seq;
    t_in_word           r_in;
    logic [PROD_W-1:0]  r_prod;
    logic [TRAVEL_W-1:0] r_travel;
    logic               r_out_valid, n_out_valid;
    t_out_word          r_out_word,  n_out_word;

    t_div_res           w_div;
    logic               w_in_accept;
    logic [31:0]        w_elapsed;
    logic [16:0]        w_mag4;
    logic [19:0]        w_travel;
    logic [16:0]        w_pos_dr;
    logic [17:0]        w_pos_up;
    logic signed [15:0] w_cmd_sat;
    logic               w_over_limit;
    logic [31:0]        w_oc_elapsed;
    t_motion            w_m;
    logic               w_ocf;
    logic [31:0]        w_ocs;
    t_job_req           w_req;

    // magnitude of a speed; full scale fits in 15 bits
    function automatic logic [14:0] mag15(logic signed [15:0] s);
        logic signed [15:0] a;
        a = s[15] ? -s : s;
        return a[14:0];
    endfunction

    // follow the sign of the speed, a new direction starts a segment
    function automatic t_motion track(t_motion m, logic [31:0] now);
        t_motion t;
        t = m;
        if (m.speed == 16'sd0) begin
            t.mode = MODE_IDLE;
        end else if (m.speed[15] && m.mode != MODE_CLOSING) begin
            t.mode = MODE_CLOSING;
            t.seg_time = now;
            t.seg_pos = m.pos;
        end else if (!m.speed[15] && m.mode != MODE_OPENING) begin
            t.mode = MODE_OPENING;
            t.seg_time = now;
            t.seg_pos = m.pos;
        end
        return t;
    endfunction

    // apply a new speed; a real speed change restarts the segment
    function automatic t_motion drive(t_motion m, logic signed [15:0] s, logic [31:0] now);
        t_motion            t;
        logic signed [16:0] d;
        logic [16:0]        ad;
        t = m;
        d = {s[15], s} - {m.speed[15], m.speed};
        ad = d[16] ? 17'(-d) : 17'(d);
        if (m.mode != MODE_IDLE && ad > SPEED_DELTA_MIN) begin
            t.seg_time = now;
            t.seg_pos = m.pos;
        end
        t.speed = s;
        return track(t, now);
    endfunction

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_seq == SEQ_IDLE);
    assign w_in_accept = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open_travel  <= RST_OPEN_TRAVEL;
            r_close_travel <= RST_CLOSE_TRAVEL;
            r_cur_limit    <= RST_CUR_LIMIT;
            r_oc_hold      <= RST_OC_HOLD;
        end else if (i_cfg.valid) begin
            case (i_cfg.data.index)
                CFG_OPEN_TRAVEL:  r_open_travel  <= i_cfg.data.data;
                CFG_CLOSE_TRAVEL: r_close_travel <= i_cfg.data.data;
                CFG_CUR_LIMIT:    r_cur_limit    <= i_cfg.data.data[14:0];
                CFG_OC_HOLD:      r_oc_hold      <= i_cfg.data.data[15:0];
                default: ;
            endcase
        end
    end

    // progress numerator: 4 * |speed| * elapsed ms
    assign w_elapsed = r_in.now_ms - r_m.seg_time;
    assign w_mag4    = {mag15(r_m.speed), 2'b00};
    always_comb begin
        if (r_m.mode == MODE_OPENING) begin
            w_travel = (r_open_travel == 20'd0) ? 20'd1 : r_open_travel;
        end else begin
            w_travel = (r_close_travel == 20'd0) ? 20'd1 : r_close_travel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_seq == SEQ_MUL) begin
            r_prod   <= PROD_W'(w_mag4) * PROD_W'(w_elapsed);
            r_travel <= w_travel;
        end
        if (w_in_accept) begin
            r_in <= i_in.data;
        end
    end

    gmd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_seq == SEQ_LOAD),
        .i_dividend (r_prod),
        .i_divisor  (r_travel),
        .o_res      (w_div)
    );

    // dead-reckoned position, clamped at the ends and forced by the end switches
    assign w_pos_up = {1'b0, r_m.seg_pos} + {1'b0, w_div.quot};
    always_comb begin
        w_pos_dr = r_m.pos;
        if (r_in.action == ACT_TICK && r_m.mode == MODE_OPENING) begin
            if (w_div.sat || !r_in.open_switch_n || w_pos_up > {1'b0, POS_FULL}) begin
                w_pos_dr = POS_FULL;
            end else begin
                w_pos_dr = w_pos_up[16:0];
            end
        end else if (r_in.action == ACT_TICK && r_m.mode == MODE_CLOSING) begin
            if (w_div.sat || w_div.quot >= r_m.seg_pos || !r_in.close_switch_n) begin
                w_pos_dr = 17'd0;
            end else begin
                w_pos_dr = r_m.seg_pos - w_div.quot;
            end
        end
    end

    // command clipped to full scale
    always_comb begin
        if (r_in.speed_cmd > SPEED_FULL) begin
            w_cmd_sat = SPEED_FULL;
        end else if (r_in.speed_cmd < -SPEED_FULL) begin
            w_cmd_sat = -SPEED_FULL;
        end else begin
            w_cmd_sat = r_in.speed_cmd;
        end
    end

    assign w_over_limit = $signed({r_in.current_ma[15], r_in.current_ma})
                          > $signed({2'b00, r_cur_limit});
    assign w_oc_elapsed = r_in.now_ms - r_ocs;

    // one word of controller behavior, applied when the sequencer commits
    always_comb begin : step_logic
        t_motion            m;
        logic               ocf;
        logic [31:0]        ocs;
        t_job_req           req;
        logic               do_drv;
        logic signed [15:0] s;
        m = r_m;
        ocf = r_ocf;
        ocs = r_ocs;
        req = JOB_NONE;
        do_drv = 1'b0;
        s = 16'sd0;
        case (r_in.action)
            ACT_TICK: begin
                m.pos = w_pos_dr;
                if (!r_in.speed_valid) begin
                    do_drv = 1'b1;
                    req = JOB_DELETE;
                end else begin
                    m = track(m, r_in.now_ms);
                    if ((m.mode == MODE_OPENING && !r_in.open_switch_n) ||
                        (m.mode == MODE_CLOSING &&
                         (!r_in.close_switch_n || !r_in.barrier_n))) begin
                        do_drv = 1'b1;
                        req = JOB_DELETE;
                    end else begin
                        do_drv = 1'b1;
                        s = w_cmd_sat;
                    end
                end
            end
            ACT_OPEN_SW: begin
                if (m.mode != MODE_CLOSING) begin
                    do_drv = 1'b1;
                    req = JOB_DELETE;
                end
            end
            ACT_CLOSE_SW: begin
                if (m.mode != MODE_OPENING) begin
                    do_drv = 1'b1;
                    req = JOB_DELETE;
                end
            end
            ACT_BARRIER: begin
                if (m.mode == MODE_CLOSING) begin
                    do_drv = 1'b1;
                    req = JOB_REOPEN;
                end
            end
            ACT_OC_CHECK: begin
                if (w_over_limit) begin
                    // a speed at or above SPEED_HIGH sets the flag, the hold test still runs
                    if (mag15(m.speed) >= SPEED_HIGH) begin
                        ocf = 1'b1;
                    end
                    if (!ocf) begin
                        ocf = 1'b1;
                        ocs = r_in.now_ms;
                    end else if (w_oc_elapsed >= {16'd0, r_oc_hold}) begin
                        ocf = 1'b0;
                    end
                end else begin
                    ocf = 1'b0;
                end
                if (ocf) begin
                    req = (m.mode != MODE_CLOSING) ? JOB_REOPEN : JOB_DELETE;
                    do_drv = 1'b1;
                end
            end
            default: ;
        endcase
        if (do_drv) begin
            m = drive(m, s, r_in.now_ms);
        end
        w_m = m;
        w_ocf = ocf;
        w_ocs = ocs;
        w_req = req;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq       <= SEQ_IDLE;
            r_out_valid <= 1'b0;
            r_m         <= '{mode: MODE_IDLE, speed: 16'sd0, pos: 17'd0,
                             seg_pos: 17'd0, seg_time: 32'd0};
            r_ocf       <= 1'b0;
            r_ocs       <= 32'd0;
        end else begin
            r_seq       <= n_seq;
            r_out_valid <= n_out_valid;
            r_m         <= n_m;
            r_ocf       <= n_ocf;
            r_ocs       <= n_ocs;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_word <= n_out_word;
    end

    // sequencer: moving ticks go through multiply and divide, others go straight to commit
    always_comb begin
        n_seq       = r_seq;
        n_m         = r_m;
        n_ocf       = r_ocf;
        n_ocs       = r_ocs;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_word  = r_out_word;
        case (r_seq)
            SEQ_IDLE: begin
                if (w_in_accept) begin
                    if (i_in.data.action == ACT_TICK && r_m.mode != MODE_IDLE) begin
                        n_seq = SEQ_MUL;
                    end else begin
                        n_seq = SEQ_DONE;
                    end
                end
            end
            SEQ_MUL:  n_seq = SEQ_LOAD;
            SEQ_LOAD: n_seq = SEQ_DIV;
            SEQ_DIV: begin
                if (w_div.done) begin
                    n_seq = SEQ_DONE;
                end
            end
            SEQ_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_m   = w_m;
                    n_ocf = w_ocf;
                    n_ocs = w_ocs;
                    n_out_valid = 1'b1;
                    n_out_word.pwm_duty     = 8'(mag15(w_m.speed) >> 7);
                    n_out_word.direction    = w_m.speed[15];
                    n_out_word.position     = w_m.pos;
                    n_out_word.motion_state = w_m.mode;
                    n_out_word.job_request  = w_req;
                    n_out_word.overcurrent  = w_ocf;
                    n_seq = SEQ_IDLE;
                end
            end
            default: n_seq = SEQ_IDLE;
        endcase
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_word;

    // divider only finishes while the sequencer waits for it
    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div.done |-> r_seq == SEQ_DIV)
        else $error("divider finished outside of the divide phase");

    // position estimate stays within the travel range
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m.pos <= POS_FULL)
        else $error("position beyond fully open");

    // motion state follows the sign of the stored speed
    a_mode_speed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_m.mode == MODE_IDLE) == (r_m.speed == 16'sd0)) &&
        (r_m.mode != MODE_OPENING || !r_m.speed[15]) &&
        (r_m.mode != MODE_CLOSING || r_m.speed[15]))
        else $error("motion state disagrees with speed");

endmodule

// ===== dv/gate_motor_drive_controller_tb.sv =====
// self-checking testbench of the gate motor drive controller against a behavioral predictor
module gate_motor_drive_controller_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gmd_pkg::*;

    // action codes the block ignores
    localparam logic [2:0] ACT_RSVD     = 3'd5;
    localparam logic [2:0] ACT_RSVD_TOP = 3'd7;

    localparam int N_DIR        = 26;
    localparam int N_FIXED      = 4;
    localparam int N_PHASE      = 6;
    localparam int PHASE_WORDS  = 220;
    localparam int STALL_LONG   = 150;
    localparam int SETTLE_TICKS = 30;

    typedef struct {
        logic [2:0]         act;
        logic [31:0]        now;
        logic signed [15:0] cmd;
        logic [3:0]         lv;     // speed_valid, open_switch_n, close_switch_n, barrier_n
        logic signed [15:0] cur;
        bit                 typed;  // result written out in the row
        t_out_word          res;
    } t_row;

    typedef struct {
        logic [19:0] open_t;
        logic [19:0] close_t;
        logic [19:0] limit;
        logic [19:0] hold;
    } t_setting;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    gmd_stream_if #(.t_payload(t_cfg_word)) cfg_if ();
    gmd_stream_if #(.t_payload(t_in_word))  in_if ();
    gmd_stream_if #(.t_payload(t_out_word)) out_if ();

    gate_motor_drive_controller uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // register copies
    logic [19:0] open_travel;
    logic [19:0] close_travel;
    logic [14:0] cur_limit;
    logic [15:0] oc_hold;

    // controller state as predicted
    t_motion_mode       gate_mode;
    logic signed [15:0] gate_speed;
    logic [16:0]        gate_pos;
    logic [16:0]        seg_pos;
    logic [31:0]        seg_time;
    bit                 oc_flag;
    logic [31:0]        oc_since;

    t_out_word outputs_due[$];
    int        mismatches;
    int        words_seen;

    // shared between the two sides
    bit steady_flow;
    bit stall_outputs;

    // random scenario state
    logic [31:0] clock_ms;
    int          run_speed;

    const t_row dir_tab [N_DIR] = '{
        // after reset: tick without a speed ends the job
        '{ACT_TICK, 0, 0, 4'b0111, 0, 1'b1, '{8'd0, 1'b0, 17'd0, MODE_IDLE, JOB_DELETE, 1'b0}},
        '{ACT_RSVD, 5, 0, 4'b1111, 0, 1'b1, '{8'd0, 1'b0, 17'd0, MODE_IDLE, JOB_NONE, 1'b0}},
        '{ACT_RSVD_TOP, 6, -1, 4'b0000, -1, 1'b1,
          '{8'd0, 1'b0, 17'd0, MODE_IDLE, JOB_NONE, 1'b0}},
        // overcurrent while idle asks for a reopen, then clears
        '{ACT_OC_CHECK, 100, 0, 4'b1111, 32767, 1'b1,
          '{8'd0, 1'b0, 17'd0, MODE_IDLE, JOB_REOPEN, 1'b1}},
        '{ACT_OC_CHECK, 200, 0, 4'b1111, -32768, 1'b1,
          '{8'd0, 1'b0, 17'd0, MODE_IDLE, JOB_NONE, 1'b0}},
        // command above full scale saturates
        '{ACT_TICK, 1000, 32767, 4'b1111, 0, 1'b1,
          '{8'd128, 1'b0, 17'd0, MODE_OPENING, JOB_NONE, 1'b0}},
        '{ACT_TICK, 6000, 16384, 4'b1111, 0, 1'b0, '0},
        '{ACT_TICK, 30000, 16384, 4'b1111, 0, 1'b0, '0},     // runs into the open limit
        '{ACT_CLOSE_SW, 30050, 0, 4'b1111, 0, 1'b0, '0},     // opposite switch, no effect
        '{ACT_BARRIER, 30100, 0, 4'b1111, 0, 1'b0, '0},      // barrier not closing
        '{ACT_OC_CHECK, 30200, 0, 4'b1111, 6000, 1'b0, '0},  // full speed, stale hold time
        '{ACT_TICK, 31000, -32768, 4'b1011, 0, 1'b0, '0},    // open switch reached
        '{ACT_TICK, 32000, -16384, 4'b1111, 0, 1'b0, '0},
        '{ACT_TICK, 37000, -8000, 4'b1111, 0, 1'b0, '0},
        '{ACT_OPEN_SW, 37100, 0, 4'b1111, 0, 1'b0, '0},
        '{ACT_OC_CHECK, 38000, 0, 4'b1111, 5001, 1'b0, '0},  // overcurrent while closing
        '{ACT_TICK, 40000, -16384, 4'b1111, 0, 1'b0, '0},
        '{ACT_BARRIER, 41000, 0, 4'b1111, 0, 1'b0, '0},      // barrier event while closing
        '{ACT_TICK, 42000, -16384, 4'b1111, 0, 1'b0, '0},
        '{ACT_TICK, 43000, -16384, 4'b1110, 0, 1'b0, '0},    // beam cut on a tick
        '{ACT_TICK, 44000, -16384, 4'b1111, 0, 1'b0, '0},
        '{ACT_TICK, 50000, -16384, 4'b1101, 0, 1'b0, '0},    // close switch reached
        '{ACT_OPEN_SW, 51000, 0, 4'b1111, 0, 1'b0, '0},      // switch event while idle
        '{ACT_TICK, 32'hFFFF_FF00, 100, 4'b1111, 0, 1'b0, '0},
        '{ACT_TICK, 32'h0000_0100, 100, 4'b1111, 0, 1'b0, '0}, // timestamp wraps
        '{ACT_CLOSE_SW, 32'h0000_0200, 0, 4'b1111, 0, 1'b0, '0}
    };

    const t_setting set_tab [N_FIXED] = '{
        '{20'd1000, 20'd1500, 20'd5000, 20'd500},
        '{20'd0, 20'd0, 20'd0, 20'd0},
        '{20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF},
        '{20'd600000, 20'd1, 20'd1000, 20'd100}
    };

    function automatic int speed_mag();
        return (gate_speed < 0) ? -int'(gate_speed) : int'(gate_speed);
    endfunction

    // a new motion direction opens a new segment
    function automatic void follow_mode(input logic [31:0] now);
        if (gate_speed == 0) begin
            gate_mode = MODE_IDLE;
        end else if (gate_speed < 0 && gate_mode != MODE_CLOSING) begin
            gate_mode = MODE_CLOSING;
            seg_time  = now;
            seg_pos   = gate_pos;
        end else if (gate_speed > 0 && gate_mode != MODE_OPENING) begin
            gate_mode = MODE_OPENING;
            seg_time  = now;
            seg_pos   = gate_pos;
        end
    endfunction

    function automatic void apply_speed(input int s, input logic [31:0] now);
        int d;
        d = s - int'(gate_speed);
        if (d < 0) d = -d;
        if (gate_mode != MODE_IDLE && d > int'(SPEED_DELTA_MIN)) begin
            seg_time = now;
            seg_pos  = gate_pos;
        end
        gate_speed = 16'(s);
        follow_mode(now);
    endfunction

    // dead reckoning over the current segment, clamped at the ends
    function automatic void advance_position(input logic [31:0] now, input bit open_hit,
                                             input bit close_hit);
        logic [31:0]     span;
        longint unsigned travel;
        longint unsigned moved;
        longint unsigned p;
        span = now - seg_time;
        if (gate_mode == MODE_OPENING) begin
            travel = (open_travel == 0) ? 64'd1 : 64'(open_travel);
            moved  = longint'(speed_mag()) * 4 * span / travel;
            p      = seg_pos + moved;
            if (open_hit || p > POS_FULL) p = POS_FULL;
            gate_pos = 17'(p);
        end else if (gate_mode == MODE_CLOSING) begin
            travel = (close_travel == 0) ? 64'd1 : 64'(close_travel);
            moved  = longint'(speed_mag()) * 4 * span / travel;
            p      = (moved >= seg_pos) ? 64'd0 : seg_pos - moved;
            if (close_hit) p = 0;
            gate_pos = 17'(p);
        end
    endfunction

    function automatic t_out_word control_step(input t_in_word w);
        t_out_word   r;
        t_job_req    job;
        int          cmd;
        int          cur;
        bit          open_hit;
        bit          close_hit;
        bit          bar_hit;
        logic [31:0] held;
        cmd       = $signed(w.speed_cmd);
        cur       = $signed(w.current_ma);
        open_hit  = !w.open_switch_n;
        close_hit = !w.close_switch_n;
        bar_hit   = !w.barrier_n;
        job       = JOB_NONE;
        if (cmd > int'(SPEED_FULL)) cmd = int'(SPEED_FULL);
        if (cmd < -int'(SPEED_FULL)) cmd = -int'(SPEED_FULL);
        case (w.action)
            ACT_TICK: begin
                advance_position(w.now_ms, open_hit, close_hit);
                if (!w.speed_valid) begin
                    apply_speed(0, w.now_ms);
                    job = JOB_DELETE;
                end else begin
                    follow_mode(w.now_ms);
                    if ((gate_mode == MODE_OPENING && open_hit) ||
                        (gate_mode == MODE_CLOSING && (close_hit || bar_hit))) begin
                        apply_speed(0, w.now_ms);
                        job = JOB_DELETE;
                    end else begin
                        apply_speed(cmd, w.now_ms);
                    end
                end
            end
            ACT_OPEN_SW: begin
                if (gate_mode != MODE_CLOSING) begin
                    apply_speed(0, w.now_ms);
                    job = JOB_DELETE;
                end
            end
            ACT_CLOSE_SW: begin
                if (gate_mode != MODE_OPENING) begin
                    apply_speed(0, w.now_ms);
                    job = JOB_DELETE;
                end
            end
            ACT_BARRIER: begin
                if (gate_mode == MODE_CLOSING) begin
                    apply_speed(0, w.now_ms);
                    job = JOB_REOPEN;
                end
            end
            ACT_OC_CHECK: begin
                if (cur > int'(cur_limit)) begin
                    // at or above SPEED_HIGH the flag is raised at once, the hold test still runs
                    if (speed_mag() >= int'(SPEED_HIGH)) oc_flag = 1'b1;
                    held = w.now_ms - oc_since;
                    if (!oc_flag) begin
                        oc_flag  = 1'b1;
                        oc_since = w.now_ms;
                    end else if (held >= 32'(oc_hold)) begin
                        oc_flag = 1'b0;
                    end
                end else begin
                    oc_flag = 1'b0;
                end
                if (oc_flag) begin
                    job = (gate_mode != MODE_CLOSING) ? JOB_REOPEN : JOB_DELETE;
                    apply_speed(0, w.now_ms);
                end
            end
            default: ;
        endcase
        r.pwm_duty     = 8'(speed_mag() >> 7);
        r.direction    = gate_speed < 0;
        r.position     = gate_pos;
        r.motion_state = gate_mode;
        r.job_request  = job;
        r.overcurrent  = oc_flag;
        return r;
    endfunction

    // mostly motion runs with a held speed, plus events, noise and time jumps
    function automatic t_in_word random_word();
        t_in_word w;
        int       pick;
        int       roll;
        roll = $urandom_range(0, 99);
        if (roll < 3) clock_ms = $urandom();
        else if (roll < 8) clock_ms += $urandom_range(0, 100000);
        else clock_ms += $urandom_range(0, 300);
        w.now_ms = clock_ms;
        pick = $urandom_range(0, 99);
        if (pick < 72) w.action = ACT_TICK;
        else if (pick < 80) w.action = ACT_OC_CHECK;
        else if (pick < 86) w.action = ACT_OPEN_SW;
        else if (pick < 92) w.action = ACT_CLOSE_SW;
        else if (pick < 97) w.action = ACT_BARRIER;
        else w.action = 3'($urandom_range(ACT_RSVD, ACT_RSVD_TOP));
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
            run_speed = int'($urandom_range(0, 32768)) - 16384;
        end else if (roll < 14) begin
            case ($urandom_range(0, 2))
                0: run_speed = int'(SPEED_FULL);
                1: run_speed = -int'(SPEED_FULL);
                default: run_speed = 0;
            endcase
        end else if (roll < 22) begin
            // small changes around the segment restart threshold
            run_speed += int'($urandom_range(0, 34)) - 17;
            if (run_speed > int'(SPEED_FULL)) run_speed = int'(SPEED_FULL);
            if (run_speed < -int'(SPEED_FULL)) run_speed = -int'(SPEED_FULL);
        end
        w.speed_cmd      = ($urandom_range(0, 99) < 4) ? 16'($urandom()) : 16'(run_speed);
        w.speed_valid    = $urandom_range(0, 99) < 96;
        w.open_switch_n  = $urandom_range(0, 99) >= 6;
        w.close_switch_n = $urandom_range(0, 99) >= 6;
        w.barrier_n      = $urandom_range(0, 99) >= 5;
        case ($urandom_range(0, 2))
            0: w.current_ma = 16'($urandom());
            1: w.current_ma = 16'(int'(cur_limit) + int'($urandom_range(0, 8)) - 4);
            default: w.current_ma = 16'(int'(cur_limit) + int'($urandom_range(0, 3000)));
        endcase
        return w;
    endfunction

    task automatic flag_mismatch(input string what, input longint got, input longint want);
        mismatches++;
        if (mismatches <= 60)
            $display("mismatch at output word %0d: %s got %0h want %0h",
                     words_seen, what, got, want);
    endtask

    task automatic compare_outputs(input t_out_word got);
        t_out_word want;
        words_seen++;
        if (outputs_due.size() == 0) begin
            flag_mismatch("unexpected word", longint'(got), 0);
            return;
        end
        want = outputs_due[0];
        outputs_due.delete(0);
        if (got.pwm_duty !== want.pwm_duty)
            flag_mismatch("pwm_duty", got.pwm_duty, want.pwm_duty);
        if (got.direction !== want.direction)
            flag_mismatch("direction", got.direction, want.direction);
        if (got.position !== want.position)
            flag_mismatch("position", got.position, want.position);
        if (got.motion_state !== want.motion_state)
            flag_mismatch("motion_state", got.motion_state, want.motion_state);
        if (got.job_request !== want.job_request)
            flag_mismatch("job_request", got.job_request, want.job_request);
        if (got.overcurrent !== want.overcurrent)
            flag_mismatch("overcurrent", got.overcurrent, want.overcurrent);
    endtask

    // keeps valid high when the next word follows without a gap
    task automatic send_word(input t_in_word w, input bit typed, input t_out_word typed_res);
        int        gap;
        t_out_word model_res;
        gap = steady_flow ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= w;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        model_res = control_step(w);
        outputs_due = {outputs_due, (typed ? typed_res : model_res)};
    endtask

    task automatic drain_outputs();
        in_if.valid <= 1'b0;
        while (outputs_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [19:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= '{index: idx, data: val};
        do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
        case (idx)
            CFG_OPEN_TRAVEL:  open_travel  = val;
            CFG_CLOSE_TRAVEL: close_travel = val;
            CFG_CUR_LIMIT:    cur_limit    = val[14:0];
            CFG_OC_HOLD:      oc_hold      = val[15:0];
            default: ;
        endcase
    endtask

    // registers change only with nothing in flight
    task automatic load_setting(input t_setting s);
        drain_outputs();
        write_reg(CFG_OPEN_TRAVEL, s.open_t);
        write_reg(CFG_CLOSE_TRAVEL, s.close_t);
        write_reg(CFG_CUR_LIMIT, s.limit);
        write_reg(CFG_OC_HOLD, s.hold);
        cfg_if.valid <= 1'b0;
    endtask

    initial begin : stimulus
        t_in_word w;
        t_setting s;
        in_if.valid  <= 1'b0;
        in_if.data   <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.data  <= '0;
        open_travel  = RST_OPEN_TRAVEL;
        close_travel = RST_CLOSE_TRAVEL;
        cur_limit    = RST_CUR_LIMIT;
        oc_hold      = RST_OC_HOLD;
        gate_mode    = MODE_IDLE;
        gate_speed   = '0;
        gate_pos     = '0;
        seg_pos      = '0;
        seg_time     = '0;
        oc_flag      = 1'b0;
        oc_since     = '0;
        clock_ms     = 32'h300;
        run_speed    = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed words
        for (int k = 0; k < N_DIR; k++) begin
            w.action      = dir_tab[k].act;
            w.now_ms      = dir_tab[k].now;
            w.speed_cmd   = dir_tab[k].cmd;
            {w.speed_valid, w.open_switch_n, w.close_switch_n, w.barrier_n} = dir_tab[k].lv;
            w.current_ma  = dir_tab[k].cur;
            send_word(w, dir_tab[k].typed, dir_tab[k].res);
        end

        // random phases, each under its own register setting
        for (int ph = 0; ph < N_PHASE; ph++) begin
            if (ph < N_FIXED) begin
                s = set_tab[ph];
            end else begin
                s.open_t  = $urandom_range(1, 5000);
                s.close_t = $urandom_range(1, 5000);
                s.limit   = $urandom_range(0, 32767);
                s.hold    = $urandom_range(0, 2000);
            end
            load_setting(s);
            for (int i = 0; i < PHASE_WORDS; i++) begin
                if (ph == 1 && i == 60) stall_outputs = 1'b1;
                if (ph == 3 && i == 100) drain_outputs();
                steady_flow = (i >= 150 && i < 190);
                send_word(random_word(), 1'b0, '0);
            end
        end
        steady_flow = 1'b0;

        drain_outputs();
        repeat (SETTLE_TICKS) @(posedge i_clk);
        if (outputs_due.size() != 0)
            flag_mismatch("words never delivered", outputs_due.size(), 0);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // result side: random stalls, one long hold-off when asked
    initial begin : result_side
        int stall;
        bit long_hold;
        out_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            long_hold = stall_outputs;
            if (long_hold) stall = STALL_LONG;
            else if (steady_flow) stall = 0;
            else stall = $urandom_range(0, 5);
            if (stall > 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            if (long_hold) stall_outputs = 1'b0;
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (out_if.valid !== 1'b1);
            compare_outputs(out_if.data);
        end
    end

    initial begin : watchdog
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
